// ===== hw/rtl/lcdn_pkg.sv =====
`default_nettype none

package lcdn_pkg;

   // Escape code after reset
   localparam logic [7:0] ESC_RESET   = 8'h1B;
   // End mark of the init table and the byte that clears the screen
   localparam logic [7:0] END_MARK    = 8'hFF;
   localparam logic [7:0] CLEAR_CMD   = 8'h01;
   localparam logic [7:0] HOME_CMD    = 8'h02;
   localparam logic [7:0] HOME_CHAR   = 8'h40;
   // Function-set detection for the switch to 4-bit mode
   localparam logic [7:0] FUNC_MASK   = 8'h30;
   localparam logic [7:0] FUNC_4BIT   = 8'h20;

   typedef enum logic [3:0] {
      PH_POWER = 4'b0001,
      PH_INIT  = 4'b0010,
      PH_READY = 4'b0100,
      PH_ESC   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] nibble;
      logic       register_select;
      logic       strobe_res;
      logic       busy_res;
      logic       last;
   } rsp_type;

   // Results of one item, handed from the decoder to the result buffer
   typedef struct packed {
      logic       valid;
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } load_type;

   // Power-up command sequence; END_MARK past its end
   function automatic logic [7:0] init_byte(input logic [3:0] pos);
      logic [7:0] b;
      unique case (pos)
         4'd0:    b = 8'h30;
         4'd1:    b = 8'h30;
         4'd2:    b = 8'h30;
         4'd3:    b = 8'h20;
         4'd4:    b = 8'h28;
         4'd5:    b = 8'h0C;
         4'd6:    b = 8'h06;
         4'd7:    b = 8'h01;
         4'd8:    b = 8'h02;
         default: b = END_MARK;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcdn_req_if.sv =====
`default_nettype none

interface lcdn_req_if;
   import lcdn_pkg::*;

   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;

   modport source (output valid, output operation, output data_byte, input ready);
   modport sink (input valid, input operation, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcdn_rsp_if.sv =====
`default_nettype none

interface lcdn_rsp_if;
   import lcdn_pkg::*;

   logic       valid;
   logic       ready;
   logic [3:0] nibble;
   logic       register_select;
   logic       strobe_res;
   logic       busy_res;
   logic       last;

   modport source (output valid, output nibble, output register_select,
                   output strobe_res, output busy_res, output last, input ready);
   modport sink (input valid, input nibble, input register_select,
                 input strobe_res, input busy_res, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcdn_csr_if.sv =====
`default_nettype none

interface lcdn_csr_if;
   import lcdn_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] escape_code;

   modport source (output valid, output escape_code, input ready);
   modport sink (input valid, input escape_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lcdn_in_stage.sv =====
`default_nettype none

module lcdn_in_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   lcdn_req_if.sink              req,
   input  wire logic             advance,
   output      logic             in_valid,
   output      lcdn_pkg::req_type item
);
   import lcdn_pkg::*;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type item_ff;
   logic    take;

   assign req.ready = !in_valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      priority if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation <= req.operation;
         item_ff.data_byte <= req.data_byte;
      end
   end

   assign in_valid = in_valid_ff;
   assign item     = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lcdn_decode.sv =====
`default_nettype none

module lcdn_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [7:0]        csr_data,
   input  wire logic              advance,
   input  wire lcdn_pkg::req_type item,
   output      lcdn_pkg::load_type load
);
   import lcdn_pkg::*;

   phase_type  phase_ff,  phase_in;
   logic [3:0] pos_ff,    pos_in;
   logic       four_ff,   four_in;
   logic [7:0] esc_ff;
   logic [7:0] table_byte;
   logic [7:0] ctrl_byte;
   logic       do_ctrl;
   logic       do_busy;
   logic       do_data;

   assign table_byte = init_byte(pos_ff);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      do_ctrl   = 1'b0;
      do_busy   = 1'b0;
      do_data   = 1'b0;
      ctrl_byte = '0;
      if (!item.operation) begin
         unique case (phase_ff)
            PH_POWER: begin
               pos_in   = '0;
               phase_in = PH_INIT;
            end
            PH_INIT: begin
               if (table_byte != END_MARK) begin
                  pos_in    = pos_ff + 4'd1;
                  do_ctrl   = 1'b1;
                  ctrl_byte = table_byte;
               end else begin
                  phase_in = PH_READY;
               end
            end
            default: ;
         endcase
      end else begin
         unique case (phase_ff)
            PH_POWER, PH_INIT: begin
               do_busy = 1'b1;
            end
            PH_READY: begin
               priority if (item.data_byte == END_MARK) begin
                  do_ctrl   = 1'b1;
                  ctrl_byte = CLEAR_CMD;
               end else if (item.data_byte == esc_ff) begin
                  phase_in = PH_ESC;
               end else begin
                  do_data = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in = PH_READY;
               priority if (item.data_byte[7]) begin
                  do_ctrl   = 1'b1;
                  ctrl_byte = item.data_byte;
               end else if (item.data_byte == HOME_CHAR) begin
                  do_ctrl   = 1'b1;
                  ctrl_byte = HOME_CMD;
               end else begin
                  do_ctrl = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Turn the decision into nibble writes or a busy refusal
   always_comb begin
      four_in      = four_ff;
      load.valid   = advance;
      load.count   = 2'd0;
      load.first   = '0;
      load.second  = '0;
      if (do_ctrl) begin
         if (four_ff) begin
            load.count  = 2'd2;
            load.first  = '{nibble: ctrl_byte[7:4], register_select: 1'b0,
                            strobe_res: 1'b1, busy_res: 1'b0, last: 1'b0};
            load.second = '{nibble: ctrl_byte[3:0], register_select: 1'b0,
                            strobe_res: 1'b1, busy_res: 1'b0, last: 1'b1};
         end else begin
            load.count = 2'd1;
            load.first = '{nibble: ctrl_byte[7:4], register_select: 1'b0,
                           strobe_res: 1'b1, busy_res: 1'b0, last: 1'b1};
            if ((ctrl_byte & FUNC_MASK) == FUNC_4BIT) begin
               four_in = 1'b1;
            end
         end
      end else if (do_busy) begin
         load.count = 2'd1;
         load.first = '{nibble: 4'd0, register_select: 1'b0,
                        strobe_res: 1'b0, busy_res: 1'b1, last: 1'b1};
      end else if (do_data) begin
         load.count  = 2'd2;
         load.first  = '{nibble: item.data_byte[7:4], register_select: 1'b1,
                         strobe_res: 1'b1, busy_res: 1'b0, last: 1'b0};
         load.second = '{nibble: item.data_byte[3:0], register_select: 1'b1,
                         strobe_res: 1'b1, busy_res: 1'b0, last: 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_POWER;
         pos_ff   <= '0;
         four_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         four_ff  <= four_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= ESC_RESET;
      end else if (csr_we) begin
         esc_ff <= csr_data;
      end
   end

   // 4-bit mode, once on, stays on until reset
   a_four_sticky: assert property (@(posedge clock) disable iff (reset)
      four_ff |=> four_ff)
      else $error("4-bit mode dropped without reset");

endmodule

`default_nettype wire

// ===== hw/rtl/lcdn_out_buf.sv =====
`default_nettype none

module lcdn_out_buf (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lcdn_pkg::load_type load,
   output      logic               can_load,
   lcdn_rsp_if.source              rsp
);
   import lcdn_pkg::*;

   logic [1:0] cnt_ff,   cnt_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign pop      = rsp.valid && rsp.ready;
   assign can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp.ready);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      priority if (load.valid) begin
         cnt_in   = load.count;
         slot0_in = load.first;
         slot1_in = load.second;
      end else if (pop) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid           = (cnt_ff != 2'd0);
   assign rsp.nibble          = slot0_ff.nibble;
   assign rsp.register_select = slot0_ff.register_select;
   assign rsp.strobe_res      = slot0_ff.strobe_res;
   assign rsp.busy_res        = slot0_ff.busy_res;
   assign rsp.last            = slot0_ff.last;

   // Never overwrite a result that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop)))
      else $error("result buffer loaded while still holding results");

   // First of a pair never carries last
   a_pair_head: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !slot0_ff.last)
      else $error("head of a nibble pair marked last");

   // A lone remaining result always ends its item
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> slot0_ff.last)
      else $error("single remaining result not marked last");

endmodule

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_interface.sv =====
`default_nettype none

// Character LCD front end for an HD44780-style panel on a 4-bit bus. Each
// req beat is a tick (operation 0) or a byte (operation 1); each rsp beat is
// one nibble write with its register-select flag, or a busy refusal for a
// byte that arrives before the power-up sequence is done. Ticks walk the
// panel from power-up through the built-in init sequence to ready. An item
// is decoded in the cycle after it is registered and, once there is room,
// its zero, one or two results go into a two-slot result buffer that sends
// one per cycle while rsp is ready, so items with one or no result go at one
// per cycle and a nibble pair holds the buffer until both are sent, set by
// the single rsp port. The user is to write the escape code register over
// the csr port only while the block is idle; the block does not enforce it
// and the port is always ready. No bus delays or queueing are modeled here.
module char_lcd_nibble_interface (
   input  wire logic clock,
   input  wire logic reset,
   lcdn_req_if.sink   req_bus,
   lcdn_rsp_if.source rsp_bus,
   lcdn_csr_if.sink   csr_bus
);
   import lcdn_pkg::*;

   logic     in_valid;
   req_type  item;
   logic     can_load;
   logic     advance;
   load_type load;

   // Config writes land in the next cycle
   assign csr_bus.ready = 1'b1;

   // Move the registered item into the result buffer once it has room
   assign advance = in_valid && can_load;

   // Hold the accepted beat
   lcdn_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .advance  (advance),
      .in_valid (in_valid),
      .item     (item)
   );

   // Decode against phase, init position and bus mode; advance that state
   lcdn_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_bus.valid),
      .csr_data (csr_bus.escape_code),
      .advance  (advance),
      .item     (item),
      .load     (load)
   );

   // Drain the nibble writes and busy refusals one beat at a time
   lcdn_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire
